>>> rtl/tfpc_pkg.sv
package tfpc_pkg;

	// calibration steps
	localparam int STEP_W = 3;
	localparam logic [STEP_W-1:0] STEP_FIRST       = 3'd0;
	localparam logic [STEP_W-1:0] STEP_LAST_CORNER = 3'd3;
	localparam logic [STEP_W-1:0] STEP_CHECK       = 3'd4;
	localparam logic [STEP_W-1:0] STEP_DONE        = 3'd5;

	// result status codes
	typedef enum logic [2:0] {
		ST_ADVANCED    = 3'd0,
		ST_REJECTED    = 3'd1,
		ST_CHECK_FAIL  = 3'd2,
		ST_COMPLETE    = 3'd3,
		ST_UNCHECKED   = 3'd4,
		ST_SENSOR_FAIL = 3'd5
	} status_t;

	// register indexes on the config port
	localparam logic [1:0] REG_CHECK_EN  = 2'd0;
	localparam logic [1:0] REG_TARGET_X  = 2'd1;
	localparam logic [1:0] REG_TARGET_Y  = 2'd2;
	localparam logic [1:0] REG_TOLERANCE = 2'd3;

	localparam int ADDR_W = 4;
	localparam int APB_W  = 32;
	localparam int TOL_W  = 8;

	// axis limit range and output packing
	localparam int LIM_W  = 14;
	localparam int LIM_LO = -1024;
	localparam int LIM_HI = 5119;
	localparam int OUT_DATA_W = 64;
	localparam int OUT_USER_W = 4;
	localparam int IN_USER_W  = 2;

	// control part of a step result
	typedef struct packed {
		logic [STEP_W-1:0] step_now;
		status_t           status;
		logic              limits_valid;
	} step_res_t;

endpackage

>>> rtl/tfpc_cfg.sv
module tfpc_cfg #(
	parameter int SCREEN_BITS = 11
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [tfpc_pkg::ADDR_W-1:0]     paddr,
	input  logic [tfpc_pkg::APB_W-1:0]      pwdata,
	output logic [tfpc_pkg::APB_W-1:0]      prdata,
	output logic                            pready,
	output logic                            check_enable,
	output logic [SCREEN_BITS-1:0]          target_x,
	output logic [SCREEN_BITS-1:0]          target_y,
	output logic [tfpc_pkg::TOL_W-1:0]      tolerance
);
	import tfpc_pkg::*;

	logic           wr_en;
	logic [1:0]     reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite && pready;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_enable <= 1'b1;
			target_x     <= SCREEN_BITS'(320);
			target_y     <= SCREEN_BITS'(240);
			tolerance    <= TOL_W'(30);
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_CHECK_EN:  check_enable <= pwdata[0];
				REG_TARGET_X:  target_x     <= pwdata[SCREEN_BITS-1:0];
				REG_TARGET_Y:  target_y     <= pwdata[SCREEN_BITS-1:0];
				REG_TOLERANCE: tolerance    <= pwdata[TOL_W-1:0];
				default:       check_enable <= check_enable;
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (reg_idx)
			REG_CHECK_EN:  prdata = APB_W'(check_enable);
			REG_TARGET_X:  prdata = APB_W'(target_x);
			REG_TARGET_Y:  prdata = APB_W'(target_y);
			REG_TOLERANCE: prdata = APB_W'(tolerance);
			default:       prdata = '0;
		endcase
	end

endmodule

>>> rtl/tfpc_step.sv
module tfpc_step #(
	parameter int RAW_BITS    = 12,
	parameter int SCREEN_BITS = 11
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  logic [RAW_BITS-1:0]           raw_x,
	input  logic [RAW_BITS-1:0]           raw_y,
	input  logic                          raw_unsettled,
	input  logic                          sensor_error,
	input  logic [SCREEN_BITS-1:0]        screen_x,
	input  logic [SCREEN_BITS-1:0]        screen_y,
	input  logic                          check_enable,
	input  logic [SCREEN_BITS-1:0]        target_x,
	input  logic [SCREEN_BITS-1:0]        target_y,
	input  logic [tfpc_pkg::TOL_W-1:0]    tolerance,
	output tfpc_pkg::step_res_t           res,
	output logic signed [RAW_BITS+3:0]    num_x_min,
	output logic signed [RAW_BITS+3:0]    num_x_max,
	output logic signed [RAW_BITS+3:0]    num_y_min,
	output logic signed [RAW_BITS+3:0]    num_y_max
);
	import tfpc_pkg::*;

	localparam int NUM_W = RAW_BITS + 4;

	logic [STEP_W-1:0]   cal_step_q;
	logic [RAW_BITS-1:0] corner_x_q [3];
	logic [RAW_BITS-1:0] corner_y_q [3];

	logic [STEP_W-1:0]   cur_step;
	logic [STEP_W-1:0]   next_step;
	status_t             status;
	logic                store;
	logic                lim_v;
	logic                far_off;
	logic [SCREEN_BITS-1:0] dist_x;
	logic [SCREEN_BITS-1:0] dist_y;
	logic [RAW_BITS:0]   sum_xa, sum_xb, sum_ya, sum_yb;
	logic [RAW_BITS-1:0] avg_xa, avg_xb, avg_ya, avg_yb;

	// 7*near - far, never overflows RAW_BITS+4 signed bits
	function automatic logic signed [NUM_W-1:0] extrap_num(
		input logic [RAW_BITS-1:0] near_v,
		input logic [RAW_BITS-1:0] far_v
	);
		logic [NUM_W-1:0] n;
		logic [NUM_W-1:0] f;
		n = NUM_W'(near_v);
		f = NUM_W'(far_v);
		return $signed((n << 3) - n - f);
	endfunction

	// a finished run restarts at the first corner
	assign cur_step = (cal_step_q >= STEP_DONE) ? STEP_FIRST : cal_step_q;

	// per-axis distance from the target
	assign dist_x  = (target_x >= screen_x) ? target_x - screen_x : screen_x - target_x;
	assign dist_y  = (target_y >= screen_y) ? target_y - screen_y : screen_y - target_y;
	assign far_off = (dist_x > SCREEN_BITS'(tolerance)) || (dist_y > SCREEN_BITS'(tolerance));

	// step sequencing
	always_comb begin
		next_step = cur_step;
		status    = ST_ADVANCED;
		store     = 1'b0;
		lim_v     = 1'b0;
		if (cur_step < STEP_CHECK) begin
			priority if (sensor_error) begin
				next_step = STEP_DONE;
				status    = ST_SENSOR_FAIL;
			end else if (raw_unsettled) begin
				status    = ST_REJECTED;
			end else begin
				store     = 1'b1;
				lim_v     = (cur_step == STEP_LAST_CORNER);
				next_step = cur_step + STEP_W'(1);
			end
		end else begin
			priority if (!check_enable) begin
				next_step = STEP_DONE;
				status    = ST_UNCHECKED;
			end else if (far_off) begin
				next_step = STEP_FIRST;
				status    = ST_CHECK_FAIL;
			end else begin
				next_step = STEP_DONE;
				status    = ST_COMPLETE;
			end
		end
	end

	// edge pair averages, the live reading is the bottom-left corner
	assign sum_xa = {1'b0, corner_x_q[0]} + {1'b0, raw_x};
	assign sum_xb = {1'b0, corner_x_q[1]} + {1'b0, corner_x_q[2]};
	assign sum_ya = {1'b0, corner_y_q[0]} + {1'b0, corner_y_q[1]};
	assign sum_yb = {1'b0, corner_y_q[2]} + {1'b0, raw_y};
	assign avg_xa = sum_xa[RAW_BITS:1];
	assign avg_xb = sum_xb[RAW_BITS:1];
	assign avg_ya = sum_ya[RAW_BITS:1];
	assign avg_yb = sum_yb[RAW_BITS:1];

	// numerators, zero when no limits go out
	assign num_x_max = lim_v ? extrap_num(avg_xb, avg_xa) : '0;
	assign num_x_min = lim_v ? extrap_num(avg_xa, avg_xb) : '0;
	assign num_y_max = lim_v ? extrap_num(avg_yb, avg_ya) : '0;
	assign num_y_min = lim_v ? extrap_num(avg_ya, avg_yb) : '0;

	assign res.step_now     = next_step;
	assign res.status       = status;
	assign res.limits_valid = lim_v;

	// step register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_step_q <= STEP_FIRST;
		end else if (fire) begin
			cal_step_q <= next_step;
		end
	end

	// corner store, last corner is used live and not kept
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (fire && store && cur_step == STEP_W'(i)) begin
				corner_x_q[i] <= raw_x;
				corner_y_q[i] <= raw_y;
			end
		end
	end

endmodule

>>> rtl/tfpc_div6.sv
module tfpc_div6 #(
	parameter int RAW_BITS = 12
) (
	input  logic signed [RAW_BITS+3:0]          num,
	output logic signed [tfpc_pkg::LIM_W-1:0]   lim
);
	import tfpc_pkg::*;

	localparam int NW = RAW_BITS + 3;
	localparam int SH = NW + 2;
	localparam int QW = (NW + 1 > 15) ? NW + 1 : 15;
	localparam logic [SH-1:0] RECIP = SH'((64'd1 << SH) / 64'd6);
	localparam logic signed [QW-1:0] SAT_LO = QW'(LIM_LO);
	localparam logic signed [QW-1:0] SAT_HI = QW'(LIM_HI);

	logic signed [NW:0]    neg;
	logic [NW-1:0]         mag;
	logic [NW+SH-1:0]      prod;
	logic [NW-1:0]         q0;
	logic [NW+2:0]         rem;
	logic [NW-1:0]         q1;
	logic signed [QW-1:0]  qpos;
	logic signed [QW-1:0]  qs;

	// magnitude, truncation toward zero is done on it
	assign neg = -num;
	assign mag = num[NW] ? neg[NW-1:0] : num[NW-1:0];

	// reciprocal estimate is low by at most one, one correction step
	assign prod = {{SH{1'b0}}, mag} * {{NW{1'b0}}, RECIP};
	assign q0   = prod[NW+SH-1:SH];
	assign rem  = {3'b000, mag} - ({3'b000, q0} * (NW+3)'(6));
	assign q1   = (rem >= (NW+3)'(6)) ? q0 + NW'(1) : q0;

	// sign back and saturate
	assign qpos = $signed({{(QW-NW){1'b0}}, q1});
	assign qs   = num[NW] ? -qpos : qpos;

	always_comb begin
		priority if (qs < SAT_LO) begin
			lim = SAT_LO[LIM_W-1:0];
		end else if (qs > SAT_HI) begin
			lim = SAT_HI[LIM_W-1:0];
		end else begin
			lim = qs[LIM_W-1:0];
		end
	end

endmodule

>>> rtl/touch_four_point_calibrator_top.sv
// channel  dir  signals                         contents
// s_       in   s_tvalid/s_tready/s_tdata/s_tuser  one touch release word
// m_       out  m_tvalid/m_tready/m_tdata/m_tuser  one step result word
// apb      in   psel/penable/pwrite/paddr/pwdata  check_enable, target_x/y, tolerance
//
// three register stages: input, step result, limits; one word per cycle sustained while
// m_tready stays high.
// the step register and corner store update as a word leaves the input stage,
// so each word sees the state its predecessor left.
// arst_n clears the step, config registers and stage valids; corners are kept.
// a stall on m_tready backs up through the stages; s_tready follows the first free stage.
module touch_four_point_calibrator_top #(
	parameter int RAW_BITS    = 12,
	parameter int SCREEN_BITS = 11
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// raw_x, raw_y, screen_x, screen_y, zero pad
	input  logic [((2*RAW_BITS+2*SCREEN_BITS+7)/8)*8-1:0] s_tdata,
	// raw_unsettled, sensor_error
	input  logic [tfpc_pkg::IN_USER_W-1:0]         s_tuser,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// step_now, x_min, x_max, y_min, y_max, zero pad
	output logic [tfpc_pkg::OUT_DATA_W-1:0]        m_tdata,
	// status, limits_valid
	output logic [tfpc_pkg::OUT_USER_W-1:0]        m_tuser,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [tfpc_pkg::ADDR_W-1:0]            paddr,
	input  logic [tfpc_pkg::APB_W-1:0]             pwdata,
	output logic [tfpc_pkg::APB_W-1:0]             prdata,
	output logic                                   pready
);
	import tfpc_pkg::*;

	localparam int NUM_W = RAW_BITS + 4;
	localparam int RY_LO = RAW_BITS;
	localparam int SX_LO = 2 * RAW_BITS;
	localparam int SY_LO = 2 * RAW_BITS + SCREEN_BITS;
	localparam int OUT_USED = STEP_W + 4 * LIM_W;

	logic                   check_enable;
	logic [SCREEN_BITS-1:0] target_x;
	logic [SCREEN_BITS-1:0] target_y;
	logic [TOL_W-1:0]       tolerance;

	logic en_s1, en_s2, en_s3;

	logic                   valid_s1;
	logic [RAW_BITS-1:0]    raw_x_s1, raw_y_s1;
	logic                   unsettled_s1, sensor_err_s1;
	logic [SCREEN_BITS-1:0] screen_x_s1, screen_y_s1;

	step_res_t              step_res;
	logic signed [NUM_W-1:0] nxmin, nxmax, nymin, nymax;

	logic                   valid_s2;
	step_res_t              res_s2;
	logic signed [NUM_W-1:0] nxmin_s2, nxmax_s2, nymin_s2, nymax_s2;

	logic signed [LIM_W-1:0] xmin, xmax, ymin, ymax;

	logic                   valid_s3;
	step_res_t              res_s3;
	logic signed [LIM_W-1:0] xmin_s3, xmax_s3, ymin_s3, ymax_s3;

	// stage enables
	assign en_s3    = !valid_s3 || m_tready;
	assign en_s2    = !valid_s2 || en_s3;
	assign en_s1    = !valid_s1 || en_s2;
	assign s_tready = en_s1;

	tfpc_cfg #(
		.SCREEN_BITS(SCREEN_BITS)
	) u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.check_enable (check_enable),
		.target_x     (target_x),
		.target_y     (target_y),
		.tolerance    (tolerance)
	);

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= s_tvalid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (en_s1 && s_tvalid) begin
			raw_x_s1      <= s_tdata[RAW_BITS-1:0];
			raw_y_s1      <= s_tdata[RY_LO+RAW_BITS-1:RY_LO];
			screen_x_s1   <= s_tdata[SX_LO+SCREEN_BITS-1:SX_LO];
			screen_y_s1   <= s_tdata[SY_LO+SCREEN_BITS-1:SY_LO];
			unsettled_s1  <= s_tuser[0];
			sensor_err_s1 <= s_tuser[1];
		end
	end

	tfpc_step #(
		.RAW_BITS    (RAW_BITS),
		.SCREEN_BITS (SCREEN_BITS)
	) u_step (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (valid_s1 && en_s2),
		.raw_x         (raw_x_s1),
		.raw_y         (raw_y_s1),
		.raw_unsettled (unsettled_s1),
		.sensor_error  (sensor_err_s1),
		.screen_x      (screen_x_s1),
		.screen_y      (screen_y_s1),
		.check_enable  (check_enable),
		.target_x      (target_x),
		.target_y      (target_y),
		.tolerance     (tolerance),
		.res           (step_res),
		.num_x_min     (nxmin),
		.num_x_max     (nxmax),
		.num_y_min     (nymin),
		.num_y_max     (nymax)
	);

	// step result stage
	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			res_s2   <= step_res;
			nxmin_s2 <= nxmin;
			nxmax_s2 <= nxmax;
			nymin_s2 <= nymin;
			nymax_s2 <= nymax;
		end
	end

	tfpc_div6 #(.RAW_BITS(RAW_BITS)) u_div_xmin (.num(nxmin_s2), .lim(xmin));
	tfpc_div6 #(.RAW_BITS(RAW_BITS)) u_div_xmax (.num(nxmax_s2), .lim(xmax));
	tfpc_div6 #(.RAW_BITS(RAW_BITS)) u_div_ymin (.num(nymin_s2), .lim(ymin));
	tfpc_div6 #(.RAW_BITS(RAW_BITS)) u_div_ymax (.num(nymax_s2), .lim(ymax));

	// output stage
	always_ff @(posedge clk) begin
		if (en_s3 && valid_s2) begin
			res_s3  <= res_s2;
			xmin_s3 <= xmin;
			xmax_s3 <= xmax;
			ymin_s3 <= ymin;
			ymax_s3 <= ymax;
		end
	end

	// output word packing
	assign m_tvalid = valid_s3;
	assign m_tdata  = {{(OUT_DATA_W-OUT_USED){1'b0}}, ymax_s3, ymin_s3, xmax_s3, xmin_s3,
		res_s3.step_now};
	assign m_tuser  = {res_s3.limits_valid, res_s3.status};

endmodule

>>> sim/touch_four_point_calibrator_top_tb.sv
module touch_four_point_calibrator_top_tb;
	import tfpc_pkg::*;

	localparam int RAW_W     = 12;
	localparam int SCR_W     = 11;
	localparam int IN_DATA_W = ((2*RAW_W+2*SCR_W+7)/8)*8;
	localparam int MAX_REPORTS = 100;

	// one touch release as the sender sees it
	typedef struct {
		logic [RAW_W-1:0] raw_x;
		logic [RAW_W-1:0] raw_y;
		logic             unsettled;
		logic             sensor_err;
		logic [SCR_W-1:0] screen_x;
		logic [SCR_W-1:0] screen_y;
	} touch_t;

	// one step result as it leaves the block
	typedef struct packed {
		logic [STEP_W-1:0] step_now;
		status_t           status;
		logic              limits_valid;
		logic [LIM_W-1:0]  x_min;
		logic [LIM_W-1:0]  x_max;
		logic [LIM_W-1:0]  y_min;
		logic [LIM_W-1:0]  y_max;
	} step_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	// raw_x, raw_y, screen_x, screen_y, zero pad
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	// raw_unsettled, sensor_error
	logic [IN_USER_W-1:0]  s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// step_now, x_min, x_max, y_min, y_max, zero pad
	logic [OUT_DATA_W-1:0] m_tdata;
	// status, limits_valid
	logic [OUT_USER_W-1:0] m_tuser;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [ADDR_W-1:0]     paddr = '0;
	logic [APB_W-1:0]      pwdata = '0;
	logic [APB_W-1:0]      prdata;
	logic                  pready;

	touch_four_point_calibrator_top #(
		.RAW_BITS(RAW_W),
		.SCREEN_BITS(SCR_W)
	) uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	// calibration state mirrored by the predictor
	logic [STEP_W-1:0] cal_step = STEP_FIRST;
	int                corner_x [4];
	int                corner_y [4];
	logic              run_failed = 1'b0;

	// register values as last written
	logic cfg_check_en = 1'b1;
	int   cfg_target_x = 320;
	int   cfg_target_y = 240;
	int   cfg_tol      = 30;

	touch_t       touch_queue[$];
	step_result_t step_results_due[$];
	touch_t       touch_on_bus;
	int           mismatches = 0;
	int           tx_idle_pct = 0;
	int           rx_idle_pct = 0;
	logic         tx_pause = 1'b0;
	logic         rx_hold = 1'b0;

	// (7*near - far)/6 toward zero, clipped to the output range
	function automatic logic [LIM_W-1:0] extrapolate_limit(input int near_v, input int far_v);
		int v;
		v = (7 * near_v - far_v) / 6;
		if (v < LIM_LO)
			v = LIM_LO;
		if (v > LIM_HI)
			v = LIM_HI;
		return LIM_W'(v);
	endfunction

	// advance the calibration sequence by one touch release
	function automatic step_result_t calibrate_step(input touch_t t);
		step_result_t r;
		int a, b, dx, dy;
		r = '0;
		r.status = ST_ADVANCED;
		if (cal_step >= STEP_DONE) begin
			cal_step = STEP_FIRST;
			run_failed = 1'b0;
		end
		if (cal_step < STEP_CHECK) begin
			if (t.sensor_err) begin
				cal_step = STEP_DONE;
				run_failed = 1'b1;
				r.status = ST_SENSOR_FAIL;
			end else if (t.unsettled) begin
				r.status = ST_REJECTED;
			end else begin
				corner_x[cal_step[1:0]] = t.raw_x;
				corner_y[cal_step[1:0]] = t.raw_y;
				if (cal_step == STEP_LAST_CORNER) begin
					// left pair against right pair, top pair against bottom pair
					a = (corner_x[0] + corner_x[3]) / 2;
					b = (corner_x[1] + corner_x[2]) / 2;
					r.x_max = extrapolate_limit(b, a);
					r.x_min = extrapolate_limit(a, b);
					a = (corner_y[0] + corner_y[1]) / 2;
					b = (corner_y[2] + corner_y[3]) / 2;
					r.y_max = extrapolate_limit(b, a);
					r.y_min = extrapolate_limit(a, b);
					r.limits_valid = 1'b1;
				end
				cal_step = cal_step + 1'b1;
			end
		end else if (cfg_check_en) begin
			dx = cfg_target_x - int'(t.screen_x);
			dy = cfg_target_y - int'(t.screen_y);
			if (dx < -cfg_tol || dx > cfg_tol || dy < -cfg_tol || dy > cfg_tol) begin
				cal_step = STEP_FIRST;
				r.status = ST_CHECK_FAIL;
			end else begin
				cal_step = STEP_DONE;
				r.status = ST_COMPLETE;
			end
		end else begin
			cal_step = STEP_DONE;
			r.status = ST_UNCHECKED;
		end
		r.step_now = cal_step;
		return r;
	endfunction

	function automatic touch_t make_touch(input int rx, input int ry, input bit uns,
			input bit serr, input int sx, input int sy);
		touch_t t;
		t.raw_x = RAW_W'(rx);
		t.raw_y = RAW_W'(ry);
		t.unsettled = uns;
		t.sensor_err = serr;
		t.screen_x = SCR_W'(sx);
		t.screen_y = SCR_W'(sy);
		return t;
	endfunction

	// screen coordinate just inside or just outside the tolerance window
	function automatic int near_target(input int centre);
		int v;
		v = centre + int'($urandom_range(2 * cfg_tol + 4)) - (cfg_tol + 2);
		if (v < 0)
			v = 0;
		if (v > 2047)
			v = 2047;
		return v;
	endfunction

	function automatic int random_raw();
		if ($urandom_range(9) == 0)
			return $urandom_range(1) ? 4095 : 0;
		return $urandom_range(4095);
	endfunction

	function automatic touch_t random_touch();
		touch_t t;
		t = make_touch(random_raw(), random_raw(), $urandom_range(99) < 8,
			$urandom_range(99) < 3, $urandom_range(2047), $urandom_range(2047));
		if ($urandom_range(99) < 65) begin
			t.screen_x = SCR_W'(near_target(cfg_target_x));
			t.screen_y = SCR_W'(near_target(cfg_target_y));
		end
		return t;
	endfunction

	// sender: predict on accept, then offer the next pending word
	always @(posedge clk) begin
		touch_t nxt;
		if (s_tvalid && s_tready)
			step_results_due.push_back(calibrate_step(touch_on_bus));
		if (!s_tvalid || s_tready) begin
			if (!tx_pause && touch_queue.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
				nxt = touch_queue.pop_front();
				touch_on_bus <= nxt;
				s_tvalid <= 1'b1;
				s_tdata <= {2'b00, nxt.screen_y, nxt.screen_x, nxt.raw_y, nxt.raw_x};
				s_tuser <= {nxt.sensor_err, nxt.unsettled};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	task automatic report_field(input string name, input int exp_v, input int act_v);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
	endtask

	// receiver: check each accepted result against the oldest prediction
	always @(posedge clk) begin
		step_result_t exp_r, act_r;
		if (m_tvalid && m_tready) begin
			act_r.step_now = m_tdata[2:0];
			act_r.x_min = m_tdata[16:3];
			act_r.x_max = m_tdata[30:17];
			act_r.y_min = m_tdata[44:31];
			act_r.y_max = m_tdata[58:45];
			act_r.status = status_t'(m_tuser[2:0]);
			act_r.limits_valid = m_tuser[3];
			if (step_results_due.size() == 0) begin
				report_field("unexpected word, step_now", -1, act_r.step_now);
			end else begin
				exp_r = step_results_due.pop_front();
				if (act_r.step_now != exp_r.step_now)
					report_field("step_now", exp_r.step_now, act_r.step_now);
				if (act_r.status != exp_r.status)
					report_field("status", exp_r.status, act_r.status);
				if (act_r.limits_valid != exp_r.limits_valid)
					report_field("limits_valid", exp_r.limits_valid, act_r.limits_valid);
				if (act_r.x_min != exp_r.x_min)
					report_field("x_min", $signed(exp_r.x_min), $signed(act_r.x_min));
				if (act_r.x_max != exp_r.x_max)
					report_field("x_max", $signed(exp_r.x_max), $signed(act_r.x_max));
				if (act_r.y_min != exp_r.y_min)
					report_field("y_min", $signed(exp_r.y_min), $signed(act_r.y_min));
				if (act_r.y_max != exp_r.y_max)
					report_field("y_max", $signed(exp_r.y_max), $signed(act_r.y_max));
			end
		end
		m_tready <= !rx_hold && $urandom_range(99) >= rx_idle_pct;
	end

	// config write: setup then access, junk above the register width
	task automatic reg_write(input logic [1:0] idx, input int val, input int w);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= ($urandom() << w) | APB_W'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_CHECK_EN:  cfg_check_en = val[0];
			REG_TARGET_X:  cfg_target_x = val;
			REG_TARGET_Y:  cfg_target_y = val;
			REG_TOLERANCE: cfg_tol = val;
			default: ;
		endcase
		@(negedge clk);
	endtask

	// wait until every word is sent and answered, then let the pipe settle
	task automatic drain();
		while (touch_queue.size() != 0 || step_results_due.size() != 0 || s_tvalid)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	initial begin
		int en, tx, ty, tol, n;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed walk through the sequence and its special cases
		tx_idle_pct = 36;
		rx_idle_pct = 88;
		touch_queue.push_back(make_touch(0, 0, 0, 0, 0, 0));
		touch_queue.push_back(make_touch(4095, 0, 1, 0, 5, 5));
		touch_queue.push_back(make_touch(4095, 0, 0, 0, 2047, 2047));
		touch_queue.push_back(make_touch(4095, 4095, 0, 0, 0, 2047));
		touch_queue.push_back(make_touch(0, 4095, 0, 0, 2047, 0));
		// sensor error is ignored at the check step
		touch_queue.push_back(make_touch(4095, 4095, 1, 1, 320, 240));
		// event when finished restarts, sensor error beats unsettled
		touch_queue.push_back(make_touch(10, 20, 1, 1, 0, 0));
		touch_queue.push_back(make_touch(2048, 2048, 0, 0, 0, 0));
		touch_queue.push_back(make_touch(4095, 4095, 0, 0, 0, 0));
		touch_queue.push_back(make_touch(1, 2, 0, 1, 0, 0));
		touch_queue.push_back(make_touch(100, 200, 0, 0, 0, 0));
		touch_queue.push_back(make_touch(3000, 150, 0, 0, 0, 0));
		touch_queue.push_back(make_touch(2900, 3900, 0, 0, 0, 0));
		touch_queue.push_back(make_touch(5, 5, 1, 0, 0, 0));
		touch_queue.push_back(make_touch(120, 3800, 0, 0, 0, 0));
		// just outside the window: back to the first corner
		touch_queue.push_back(make_touch(0, 0, 0, 0, 351, 240));
		repeat (4) touch_queue.push_back(make_touch(4095, 4095, 0, 0, 0, 0));
		// window corner exactly at the tolerance
		touch_queue.push_back(make_touch(0, 0, 0, 0, 350, 210));
		repeat (4) touch_queue.push_back(make_touch(0, 0, 0, 0, 2047, 2047));
		touch_queue.push_back(make_touch(0, 0, 0, 0, 289, 271));

		for (int p = 0; p < 6; p++) begin
			drain();
			en = 1;
			tx = $urandom_range(2047);
			ty = $urandom_range(2047);
			tol = $urandom_range(255);
			case (p)
				1: begin tx = 0; ty = 0; tol = 0; end
				2: begin tx = 2047; ty = 2047; tol = 255; end
				3: en = 0;
				4: begin tx = 320; ty = 240; tol = 30; end
				5: tol = 255;
				default: ;
			endcase
			reg_write(REG_CHECK_EN, en, 1);
			reg_write(REG_TARGET_X, tx, SCR_W);
			reg_write(REG_TARGET_Y, ty, SCR_W);
			reg_write(REG_TOLERANCE, tol, TOL_W);
			tx_idle_pct = (p < 2) ? 36 : (p < 4) ? 88 : 0;
			rx_idle_pct = (p < 2) ? 88 : (p < 4) ? 36 : 0;
			n = 330;
			if (p == 2) begin
				// sender holds back until every result is home
				repeat (n / 2) touch_queue.push_back(random_touch());
				while (touch_queue.size() != 0)
					@(negedge clk);
				tx_pause = 1'b1;
				while (s_tvalid || step_results_due.size() != 0)
					@(negedge clk);
				repeat (3) @(negedge clk);
				tx_pause = 1'b0;
				n = n - n / 2;
			end
			repeat (n) touch_queue.push_back(random_touch());
			if (p == 4) begin
				// receiver stalls long enough to back the block up
				rx_hold = 1'b1;
				repeat (300) @(negedge clk);
				rx_hold = 1'b0;
			end
		end

		drain();
		repeat (10) @(negedge clk);
		mismatches += step_results_due.size();
		if (mismatches == 0)
			$display("PASS touch_four_point_calibrator_top");
		else
			$display("FAIL touch_four_point_calibrator_top");
		$finish;
	end

	// watchdog
	initial begin
		#5000000;
		$display("FAIL touch_four_point_calibrator_top");
		$finish;
	end

endmodule
